FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Concurrent assertion that is also checked around reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

    // Input ranges and scaling constants.
    localparam logic [8:0]  HUE_WRAP   = 9'd360;
    localparam logic [5:0]  SECTOR_DEG = 6'd60;
    localparam logic [6:0]  PCT_FULL   = 7'd100;
    // One hundred percent times sixty degrees: the scale of every term.
    localparam logic [12:0] FULL_TERM  = 13'd6000;

    // 255 / 600000 reduces to 17 / 40000, and 40000 is 64 * 625.
    localparam logic [4:0]  CH_SCALE    = 5'd17;
    localparam int          PRE_SHIFT   = 6;
    // ceil(2^28 / 625); exact for every quotient input below 2^18.
    localparam logic [18:0] RECIP_M     = 19'd429497;
    localparam int          RECIP_SHIFT = 28;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t    sector;
        logic [5:0] frac;
        logic [6:0] sat;
        logic [6:0] val;
    } dec_t;

    typedef struct packed {
        sector_t     sector;
        logic [6:0]  val;
        logic [12:0] p;
        logic [12:0] q;
        logic [12:0] t;
    } term_t;

    typedef struct packed {
        logic [19:0] r;
        logic [19:0] g;
        logic [19:0] b;
    } num_t;

    // Handshake between neighbouring pipeline stages.
    typedef struct packed {
        logic valid;
        logic ready;
    } stage_ctl_t;

    // First hue of each sector.
    function automatic logic [8:0] sector_base(input sector_t sec);
        logic [8:0] base;
        case (sec)
            SEC_R_Y: base = 9'd0;
            SEC_Y_G: base = 9'd60;
            SEC_G_C: base = 9'd120;
            SEC_C_B: base = 9'd180;
            SEC_B_M: base = 9'd240;
            SEC_M_R: base = 9'd300;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hsvrgb_decode.sv
`default_nettype none

module hsvrgb_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsvrgb_pkg::stage_ctl_t ctl_in,
    input  wire logic [8:0]        hue,
    input  wire logic [6:0]        saturation,
    input  wire logic [6:0]        brightness,
    output hsvrgb_pkg::dec_t       dec_reg,
    output logic                   valid_reg
);
    import hsvrgb_pkg::*;

    logic [8:0] h_eff;
    sector_t    sector;
    dec_t       dec_next;

    always_comb
    begin
        h_eff = (hue >= HUE_WRAP) ? 9'd0 : hue;
        if (h_eff >= sector_base(SEC_M_R))
        begin
            sector = SEC_M_R;
        end
        else if (h_eff >= sector_base(SEC_B_M))
        begin
            sector = SEC_B_M;
        end
        else if (h_eff >= sector_base(SEC_C_B))
        begin
            sector = SEC_C_B;
        end
        else if (h_eff >= sector_base(SEC_G_C))
        begin
            sector = SEC_G_C;
        end
        else if (h_eff >= sector_base(SEC_Y_G))
        begin
            sector = SEC_Y_G;
        end
        else
        begin
            sector = SEC_R_Y;
        end
        dec_next.sector = sector;
        dec_next.frac   = 6'(h_eff - sector_base(sector));
        dec_next.sat    = (saturation > PCT_FULL) ? PCT_FULL : saturation;
        dec_next.val    = (brightness > PCT_FULL) ? PCT_FULL : brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.ready)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.ready && ctl_in.valid)
        begin
            dec_reg <= dec_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsvrgb_terms.sv
`default_nettype none

module hsvrgb_terms (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsvrgb_pkg::stage_ctl_t ctl_in,
    input  wire hsvrgb_pkg::dec_t  dec_reg,
    output hsvrgb_pkg::term_t      term_reg,
    output logic                   valid_reg
);
    import hsvrgb_pkg::*;

    logic [12:0] s_f;
    logic [12:0] s_nf;
    logic [5:0]  nfrac;
    term_t       term_next;

    // All terms are scaled by 6000 before the brightness multiply.
    always_comb
    begin
        nfrac = 6'(SECTOR_DEG - dec_reg.frac);
        s_f   = 13'(dec_reg.sat) * 13'(dec_reg.frac);
        s_nf  = 13'(dec_reg.sat) * 13'(nfrac);
        term_next.sector = dec_reg.sector;
        term_next.val    = dec_reg.val;
        term_next.p      = 13'(PCT_FULL - dec_reg.sat) * 13'(SECTOR_DEG);
        term_next.q      = FULL_TERM - s_f;
        term_next.t      = FULL_TERM - s_nf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.ready)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.ready && ctl_in.valid)
        begin
            term_reg <= term_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsvrgb_scale.sv
`default_nettype none

module hsvrgb_scale (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsvrgb_pkg::stage_ctl_t ctl_in,
    input  wire hsvrgb_pkg::term_t term_reg,
    output hsvrgb_pkg::num_t       num_reg,
    output logic                   valid_reg
);
    import hsvrgb_pkg::*;

    logic [12:0] r_term;
    logic [12:0] g_term;
    logic [12:0] b_term;
    num_t        num_next;

    // Standard six-sector assignment of v, p, q and t to the channels.
    always_comb
    begin
        case (term_reg.sector)
            SEC_R_Y:
            begin
                r_term = FULL_TERM;  g_term = term_reg.t; b_term = term_reg.p;
            end
            SEC_Y_G:
            begin
                r_term = term_reg.q; g_term = FULL_TERM;  b_term = term_reg.p;
            end
            SEC_G_C:
            begin
                r_term = term_reg.p; g_term = FULL_TERM;  b_term = term_reg.t;
            end
            SEC_C_B:
            begin
                r_term = term_reg.p; g_term = term_reg.q; b_term = FULL_TERM;
            end
            SEC_B_M:
            begin
                r_term = term_reg.t; g_term = term_reg.p; b_term = FULL_TERM;
            end
            default:
            begin
                r_term = FULL_TERM;  g_term = term_reg.p; b_term = term_reg.q;
            end
        endcase
        num_next.r = 20'(term_reg.val) * 20'(r_term);
        num_next.g = 20'(term_reg.val) * 20'(g_term);
        num_next.b = 20'(term_reg.val) * 20'(b_term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.ready)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.ready && ctl_in.valid)
        begin
            num_reg <= num_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsvrgb_divide.sv
`default_nettype none

module hsvrgb_divide (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsvrgb_pkg::stage_ctl_t ctl_in,
    input  wire hsvrgb_pkg::num_t  num_reg,
    output logic [7:0]             red_reg,
    output logic [7:0]             green_reg,
    output logic [7:0]             blue_reg,
    output logic                   valid_reg
);
    import hsvrgb_pkg::*;

    // floor(num * 255 / 600000) as floor(floor(num * 17 / 64) / 625),
    // the last step by reciprocal multiplication.
    function automatic logic [7:0] chan_of(input logic [19:0] num);
        logic [23:0] scaled;
        logic [17:0] pre;
        logic [36:0] prod;
        scaled = 24'(num) * 24'(CH_SCALE);
        pre    = scaled[23:PRE_SHIFT];
        prod   = 37'(pre) * 37'(RECIP_M);
        return prod[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    always_comb
    begin
        red_next   = chan_of(num_reg.r);
        green_next = chan_of(num_reg.g);
        blue_next  = chan_of(num_reg.b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl_in.ready)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.ready && ctl_in.valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsv_to_rgb_convert_core.sv
// HSV to 8-bit RGB colour converter for a pixel stream.
// Input channel: in_valid, in_stall, hue (degrees, 360 and above read as 0),
// saturation and brightness (percent, values above 100 read as 100).
// Output channel: out_valid, out_stall, red, green, blue.
// A transfer takes place on a rising clock edge with valid high and stall low.
// The pipeline has four register stages: hue decode, p/q/t terms, the
// brightness multiply per channel, and the scaling to 0..255 by a
// reciprocal multiply, which is also the output register. Throughput is
// one pixel per clock while out_stall is low, set by the four stages each
// taking a new item every cycle.
// When the receiver raises out_stall the last stage holds its result; the
// stages above keep moving until they fill, so bubbles are squeezed out.
// in_stall rises only when every stage holds a pixel and the output is
// stalled. Nothing is lost or repeated across a stall.
// Reset clears every valid flag asynchronously; no pixel is shown until
// the first input transfer has gone through the pipeline.
`default_nettype none

module hsv_to_rgb_convert_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [8:0] hue,
    input  wire logic [6:0] saturation,
    input  wire logic [6:0] brightness,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue
);
    import hsvrgb_pkg::*;

    // Per-stage valid flags and the data between stages.
    logic  dec_valid;
    logic  term_valid;
    logic  num_valid;
    dec_t  dec_reg;
    term_t term_reg;
    num_t  num_reg;

    // Control for each stage: the valid of the stage above, and whether this
    // stage may load. A stage loads when it is empty or its contents move on.
    stage_ctl_t dec_ctl;
    stage_ctl_t term_ctl;
    stage_ctl_t scale_ctl;
    stage_ctl_t div_ctl;

    always_comb
    begin
        div_ctl.valid   = num_valid;
        div_ctl.ready   = !out_valid || !out_stall;
        scale_ctl.valid = term_valid;
        scale_ctl.ready = !num_valid || div_ctl.ready;
        term_ctl.valid  = dec_valid;
        term_ctl.ready  = !term_valid || scale_ctl.ready;
        dec_ctl.valid   = in_valid;
        dec_ctl.ready   = !dec_valid || term_ctl.ready;
    end

    assign in_stall = !dec_ctl.ready;

    // Stage one: wrap the hue, find its sector and fraction, clamp percentages.
    hsvrgb_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (dec_ctl),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .dec_reg    (dec_reg),
        .valid_reg  (dec_valid)
    );

    // Stage two: the p, q and t terms before the brightness factor.
    hsvrgb_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (term_ctl),
        .dec_reg   (dec_reg),
        .term_reg  (term_reg),
        .valid_reg (term_valid)
    );

    // Stage three: sector routing and the brightness multiply, scaled by 600000.
    hsvrgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (scale_ctl),
        .term_reg  (term_reg),
        .num_reg   (num_reg),
        .valid_reg (num_valid)
    );

    // Stage four: exact floor of 255 * x, which is also the output register.
    hsvrgb_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (div_ctl),
        .num_reg   (num_reg),
        .red_reg   (red),
        .green_reg (green),
        .blue_reg  (blue),
        .valid_reg (out_valid)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hsvrgb_checker.sv
`default_nettype none

`include "assert_macros.svh"

module hsvrgb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    // A stalled result stays offered.
    `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

    // A stalled result keeps its colour.
    `ASSERT_CLK_RST(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable({red, green, blue}), "result changed while stalled")

    // The input is only held off when a result is waiting on a stalled receiver.
    `ASSERT_CLK_RST(a_stall_cause, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled without output back-pressure")

    // No result is offered and no input is held off straight after reset is released.
    `ASSERT_CLK(a_reset_empty, clk, $rose(rst_n) |-> !out_valid && !in_stall, "pipeline not empty after reset")

    // A result never appears after a stretch in which no input arrives and no result is offered.
    `ASSERT_CLK_RST(a_no_invent, clk, rst_n, !in_valid && !out_valid ##1 !in_valid && !out_valid ##1 !in_valid && !out_valid ##1 !in_valid && !out_valid |=> !out_valid, "result with no input")

endmodule

bind hsv_to_rgb_convert_core hsvrgb_checker u_hsvrgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
);

`default_nettype wire

FILE: tb/sv/hsv_to_rgb_convert_core_tb.sv
`timescale 1ns / 100ps

// The testbench drives HSV pixels into the converter and checks every RGB result.
// Inputs change on the falling edge of the clock. The checker looks at the ports on the
// rising edge. At every input transfer the checker works out the expected colour with
// its own exact integer predictor and queues it. Each output transfer is compared,
// channel by channel, with the oldest entry in that queue.

module hsv_to_rgb_convert_core_tb;

    import hsvrgb_pkg::sector_t;
    import hsvrgb_pkg::SEC_R_Y;
    import hsvrgb_pkg::SEC_Y_G;
    import hsvrgb_pkg::SEC_G_C;
    import hsvrgb_pkg::SEC_C_B;
    import hsvrgb_pkg::SEC_B_M;
    import hsvrgb_pkg::SEC_M_R;

    // Scaling of the predictor. Every term is held as a multiple of 1/600000.
    localparam int unsigned HUE_LIMIT    = 360;
    localparam int unsigned DEG_PER_SEC  = 60;
    localparam int unsigned PERCENT_MAX  = 100;
    localparam int unsigned CHANNEL_MAX  = 255;
    localparam int unsigned TERM_SCALE   = PERCENT_MAX * DEG_PER_SEC;
    localparam int unsigned COLOUR_SCALE = PERCENT_MAX * TERM_SCALE;

    // Run control. The watchdog counts cycles with no transfer on either channel.
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PIXELS   = 1500;
    localparam int STREAM_PIXELS   = 250;
    localparam int SEGMENT_PIXELS  = 100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [8:0] hue = '0;
    logic [6:0] saturation = '0;
    logic [6:0] brightness = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    // Colours still to come out of the pipeline, oldest first.
    rgb_t expected_rgb[$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    // While this is set, both sides insert random gaps and stalls.
    bit  gaps_on = 1'b0;

    hsv_to_rgb_convert_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #CLK_HALF clk = ~clk;

    // Exact conversion. The hue wraps to zero at 360 and above. Saturation and value
    // are clamped to 100. Then v, p, q and t are formed over a common denominator
    // of 600000. The sector picks which of them each channel takes. The final
    // floor(255 * x) is an integer division.
    function automatic rgb_t hsv_colour(input logic [8:0] h_in, input logic [6:0] s_in,
                                        input logic [6:0] v_in);
        int unsigned     h;
        int unsigned     s;
        int unsigned     v;
        int unsigned     frac;
        sector_t         sec;
        longint unsigned term_v;
        longint unsigned term_p;
        longint unsigned term_q;
        longint unsigned term_t;
        longint unsigned num_r;
        longint unsigned num_g;
        longint unsigned num_b;
        rgb_t            colour;
        h = (h_in >= HUE_LIMIT) ? 0 : h_in;
        s = (s_in > PERCENT_MAX) ? PERCENT_MAX : s_in;
        v = (v_in > PERCENT_MAX) ? PERCENT_MAX : v_in;
        sec = sector_t'(h / DEG_PER_SEC);
        frac = h % DEG_PER_SEC;
        term_v = v * TERM_SCALE;
        term_p = v * (PERCENT_MAX - s) * DEG_PER_SEC;
        term_q = v * (TERM_SCALE - s * frac);
        term_t = v * (TERM_SCALE - s * (DEG_PER_SEC - frac));
        case (sec)
            SEC_R_Y:
            begin
                num_r = term_v; num_g = term_t; num_b = term_p;
            end
            SEC_Y_G:
            begin
                num_r = term_q; num_g = term_v; num_b = term_p;
            end
            SEC_G_C:
            begin
                num_r = term_p; num_g = term_v; num_b = term_t;
            end
            SEC_C_B:
            begin
                num_r = term_p; num_g = term_q; num_b = term_v;
            end
            SEC_B_M:
            begin
                num_r = term_t; num_g = term_p; num_b = term_v;
            end
            default:
            begin
                num_r = term_v; num_g = term_p; num_b = term_q;
            end
        endcase
        colour.red   = 8'(num_r * CHANNEL_MAX / COLOUR_SCALE);
        colour.green = 8'(num_g * CHANNEL_MAX / COLOUR_SCALE);
        colour.blue  = 8'(num_b * CHANNEL_MAX / COLOUR_SCALE);
        return colour;
    endfunction

    function automatic void report_channel(input string name, input logic [7:0] want,
                                           input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
                         want, got);
            end
        end
    endfunction

    // Checker and watchdog. A transfer on the input side queues its prediction.
    // The queueing happens before the output side is examined in the same edge,
    // so the result is correct whatever the latency of the block is.
    always @(posedge clk)
    begin
        rgb_t oldest;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                expected_rgb.push_back(hsv_colour(hue, saturation, brightness));
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_rgb.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: result %0d/%0d/%0d with no pixel outstanding",
                                 $realtime, red, green, blue);
                    end
                end
                else
                begin
                    oldest = expected_rgb.pop_front();
                    report_channel("red", oldest.red, red);
                    report_channel("green", oldest.green, green);
                    report_channel("blue", oldest.blue, blue);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver back-pressure comes in bursts, and only while gaps are enabled. A burst
    // that is running when gaps are switched off still ends.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (gaps_on && rst_n && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Presents one pixel and returns at the falling edge after its transfer. The
    // task is always entered at a falling edge. A gap lowers in_valid, and in_valid
    // is raised again at a later edge, so the two assignments never fall in the
    // same time step.
    task automatic send_pixel(input logic [8:0] h, input logic [6:0] s,
                              input logic [6:0] v);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        brightness <= v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Random hue, mostly inside the circle. Some hues sit on or beside a sector
    // boundary, and some take the whole 9-bit range so that wrapping is hit.
    function automatic logic [8:0] random_hue();
        int unsigned pick;
        int unsigned edge_hue;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 9'($urandom_range(0, 511));
        end
        else if (pick == 1)
        begin
            edge_hue = DEG_PER_SEC * $urandom_range(0, 6) + $urandom_range(0, 2);
            return 9'((edge_hue == 0) ? 0 : edge_hue - 1);
        end
        return 9'($urandom_range(0, HUE_LIMIT - 1));
    endfunction

    // Random percentage: mostly in range, with a share of the end points and of
    // the values above 100 that are clamped.
    function automatic logic [6:0] random_percent();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 7'($urandom_range(0, 127));
        end
        else if (pick == 1)
        begin
            return ($urandom_range(0, 1) == 0) ? 7'd0 : 7'(PERCENT_MAX);
        end
        return 7'($urandom_range(0, PERCENT_MAX));
    endfunction

    // Extremes of every field, both sides of each sector boundary, hue wrapping
    // and clamping of saturation and value. Full scale must come out at exactly 255.
    task automatic test_corner_colours();
        gaps_on = 1'b0;
        send_pixel(9'd0,   7'd0,   7'd0);
        send_pixel(9'd0,   7'd100, 7'd100);
        send_pixel(9'd0,   7'd127, 7'd127);
        send_pixel(9'd511, 7'd127, 7'd127);
        send_pixel(9'd360, 7'd100, 7'd100);
        send_pixel(9'd359, 7'd100, 7'd100);
        send_pixel(9'd59,  7'd100, 7'd100);
        send_pixel(9'd60,  7'd100, 7'd100);
        send_pixel(9'd119, 7'd100, 7'd50);
        send_pixel(9'd120, 7'd100, 7'd100);
        send_pixel(9'd179, 7'd77,  7'd100);
        send_pixel(9'd180, 7'd100, 7'd100);
        send_pixel(9'd239, 7'd100, 7'd100);
        send_pixel(9'd240, 7'd100, 7'd100);
        send_pixel(9'd299, 7'd55,  7'd100);
        send_pixel(9'd300, 7'd100, 7'd100);
        send_pixel(9'd30,  7'd101, 7'd101);
        send_pixel(9'd90,  7'd50,  7'd50);
        send_pixel(9'd150, 7'd0,   7'd100);
        send_pixel(9'd210, 7'd100, 7'd0);
        send_pixel(9'd270, 7'd64,  7'd64);
        send_pixel(9'd330, 7'd1,   7'd99);
        send_pixel(9'd256, 7'd42,  7'd85);
        send_pixel(9'd426, 7'd85,  7'd42);
    endtask

    // Random pixels in segments. Most segments have gaps on both sides, but some
    // run without them, so that stretches of full rate are mixed in.
    task automatic test_random_pixels();
        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            if (n % SEGMENT_PIXELS == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            send_pixel(random_hue(), random_percent(), random_percent());
        end
    endtask

    // The last part of the run has no gaps on either side. Pixels are offered at
    // one pixel per clock, held back only while in_stall is high.
    task automatic test_full_rate_stream();
        gaps_on = 1'b0;
        for (int n = 0; n < STREAM_PIXELS; n++)
        begin
            send_pixel(random_hue(), random_percent(), random_percent());
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int waited;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_colours();
        test_random_pixels();
        test_full_rate_stream();

        // Let the pipeline drain, then keep watching for any result that should not
        // be there at all.
        waited = 0;
        while (expected_rgb.size() != 0 && waited < STALL_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_rgb.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_decode.sv
rtl/core/hsvrgb_terms.sv
rtl/core/hsvrgb_scale.sv
rtl/core/hsvrgb_divide.sv
rtl/core/hsv_to_rgb_convert_core.sv
rtl/core/hsvrgb_checker.sv
tb/sv/hsv_to_rgb_convert_core_tb.sv
